FILE: hw/rtl/pjtt_pkg.sv
// Shared types, codes and constants of the periodic job timer table.
package pjtt_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] FN_TICK   = 2'd0;
    localparam logic [1:0] FN_ADD    = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;
    localparam logic [1:0] FN_QUERY  = 2'd3;

    localparam logic [1:0] K_FIRED = 2'd0;
    localparam logic [1:0] K_IDLE  = 2'd1;
    localparam logic [1:0] K_DONE  = 2'd2;
    localparam logic [1:0] K_FULL  = 2'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] interval;
        logic [31:0] ctx;
        logic [31:0] due_sec;
        logic [19:0] due_usec;
    } pjtt_entry_t;

    typedef struct packed {
        logic        we;
        logic [6:0]  waddr;
        pjtt_entry_t wdata;
    } pjtt_wr_t;

endpackage

FILE: hw/rtl/periodic_job_timer_table_unit.sv
// Top level of the periodic job timer table.
//
// Input channel (in_valid/in_ready) carries one operation per transfer: a time
// tick, an add, a remove or a query. Output channel (out_valid/out_ready)
// carries the results, one per transfer, with last set on the final result of
// each operation. A tick gives one result per fired job, at most sixteen, or a
// single idle result when nothing is due; the other operations give one result.
// An add that fits is written to the table in the S_ADD_WR state, which also
// places its result in the output register. A query, a refused add and a
// remove walk the table, loading and then evaluating each entry, and their
// result enters the output register from S_FINISH. A tick walks all entries
// once to count due jobs, then again up to the last job that fires, each fired
// result entering the output register as its entry is evaluated; an idle result
// comes from S_FINISH. Each entry is read through the single read port of the
// table memory. A new operation is accepted in the cycle after the last result
// of the previous one enters the output register. A stalled receiver holds the
// result in the output register and the sequencer waits for it. Reset empties
// the table and clears the current time; no clearing pass is needed.
module periodic_job_timer_table_unit #(
    parameter int MAX_JOBS = pjtt_pkg::MAX_JOBS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  job_id,
    input  logic [31:0] job_interval,
    input  logic [31:0] job_context,
    input  logic [31:0] time_sec,
    input  logic [19:0] time_usec,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  fired_id,
    output logic [31:0] fired_context,
    output logic [4:0]  job_count,
    output logic        job_present,
    output logic        last
);
    import pjtt_pkg::*;

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    pjtt_wr_t    wr;
    logic [IDX_W-1:0] raddr;
    pjtt_entry_t rdata;
    logic [31:0] alu_base_sec;
    logic [31:0] alu_add_sec;
    logic [31:0] alu_ref_sec;
    logic [19:0] alu_ref_usec;
    logic [31:0] alu_sum_sec;
    logic        alu_due;

    pjtt_table #(
        .MAX_JOBS (MAX_JOBS),
        .IDX_W    (IDX_W)
    ) u_table (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    pjtt_alu u_alu (
        .base_sec (alu_base_sec),
        .add_sec  (alu_add_sec),
        .due_sec  (rdata.due_sec),
        .due_usec (rdata.due_usec),
        .ref_sec  (alu_ref_sec),
        .ref_usec (alu_ref_usec),
        .sum_sec  (alu_sum_sec),
        .due      (alu_due)
    );

    pjtt_seq #(
        .MAX_JOBS (MAX_JOBS),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .job_id        (job_id),
        .job_interval  (job_interval),
        .job_context   (job_context),
        .time_sec      (time_sec),
        .time_usec     (time_usec),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .fired_id      (fired_id),
        .fired_context (fired_context),
        .job_count     (job_count),
        .job_present   (job_present),
        .last          (last),
        .wr            (wr),
        .raddr         (raddr),
        .rdata         (rdata),
        .alu_base_sec  (alu_base_sec),
        .alu_add_sec   (alu_add_sec),
        .alu_ref_sec   (alu_ref_sec),
        .alu_ref_usec  (alu_ref_usec),
        .alu_sum_sec   (alu_sum_sec),
        .alu_due       (alu_due)
    );

endmodule

FILE: hw/rtl/pjtt_table.sv
// Job table memory: one write port and one registered read port.
module pjtt_table #(
    parameter int MAX_JOBS = pjtt_pkg::MAX_JOBS_DEF,
    parameter int IDX_W    = 4
) (
    input  logic                  clk,
    input  pjtt_pkg::pjtt_wr_t    wr,
    input  logic [IDX_W-1:0]      raddr,
    output pjtt_pkg::pjtt_entry_t rdata
);
    import pjtt_pkg::*;

    pjtt_entry_t mem [MAX_JOBS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr[IDX_W-1:0]] <= wr.wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/pjtt_alu.sv
// Shared unit: saturating seconds adder and due-time comparator.
module pjtt_alu (
    input  logic [31:0] base_sec,
    input  logic [31:0] add_sec,
    input  logic [31:0] due_sec,
    input  logic [19:0] due_usec,
    input  logic [31:0] ref_sec,
    input  logic [19:0] ref_usec,
    output logic [31:0] sum_sec,
    output logic        due
);
    logic [32:0] sum;

    assign sum     = {1'b0, base_sec} + {1'b0, add_sec};
    assign sum_sec = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign due     = (due_sec < ref_sec) || ((due_sec == ref_sec) && (due_usec <= ref_usec));

endmodule

FILE: hw/rtl/pjtt_seq.sv
// Sequencer: walks the table for each operation but an add that fits, and drives the result register.
module pjtt_seq #(
    parameter int MAX_JOBS = pjtt_pkg::MAX_JOBS_DEF,
    parameter int CNT_W    = 5,
    parameter int IDX_W    = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [7:0]            job_id,
    input  logic [31:0]           job_interval,
    input  logic [31:0]           job_context,
    input  logic [31:0]           time_sec,
    input  logic [19:0]           time_usec,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [7:0]            fired_id,
    output logic [31:0]           fired_context,
    output logic [4:0]            job_count,
    output logic                  job_present,
    output logic                  last,
    output pjtt_pkg::pjtt_wr_t    wr,
    output logic [IDX_W-1:0]      raddr,
    input  pjtt_pkg::pjtt_entry_t rdata,
    output logic [31:0]           alu_base_sec,
    output logic [31:0]           alu_add_sec,
    output logic [31:0]           alu_ref_sec,
    output logic [19:0]           alu_ref_usec,
    input  logic [31:0]           alu_sum_sec,
    input  logic                  alu_due
);
    import pjtt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD_WR = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       func_reg, func_next;
    logic [7:0]       id_reg, id_next;
    logic [31:0]      interval_reg, interval_next;
    logic [31:0]      ctx_reg, ctx_next;
    logic [31:0]      tsec_reg, tsec_next;
    logic [19:0]      tusec_reg, tusec_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      now_sec_reg, now_sec_next;
    logic [19:0]      now_usec_reg, now_usec_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic [RES_W-1:0] nfire_reg, nfire_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             pass_reg, pass_next;
    logic             present_reg, present_next;
    logic [1:0]       fin_kind_reg, fin_kind_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_id_reg, out_id_next;
    logic [31:0]      out_ctx_reg, out_ctx_next;
    logic [4:0]       out_count_reg, out_count_next;
    logic             out_present_reg, out_present_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             match;
    pjtt_entry_t      upd;

    assign out_free = !out_valid_reg || out_ready;
    assign match    = (rdata.id == id_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign raddr    = idx_reg[IDX_W-1:0];

    assign alu_base_sec = (state_reg == S_ADD_WR) ? now_sec_reg : tsec_reg;
    assign alu_add_sec  = (state_reg == S_ADD_WR) ? interval_reg : rdata.interval;
    assign alu_ref_sec  = tsec_reg;
    assign alu_ref_usec = tusec_reg;

    always_comb
    begin
        upd          = rdata;
        upd.due_sec  = alu_sum_sec;
        upd.due_usec = tusec_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        id_next          = id_reg;
        interval_next    = interval_reg;
        ctx_next         = ctx_reg;
        tsec_next        = tsec_reg;
        tusec_next       = tusec_reg;
        count_next       = count_reg;
        now_sec_next     = now_sec_reg;
        now_usec_next    = now_usec_reg;
        idx_next         = idx_reg;
        wr_idx_next      = wr_idx_reg;
        nfire_next       = nfire_reg;
        last_idx_next    = last_idx_reg;
        pass_next        = pass_reg;
        present_next     = present_reg;
        fin_kind_next    = fin_kind_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_kind_next    = out_kind_reg;
        out_id_next      = out_id_reg;
        out_ctx_next     = out_ctx_reg;
        out_count_next   = out_count_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        wr.we            = 1'b0;
        wr.waddr         = 7'(idx_reg);
        wr.wdata         = upd;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next     = func;
                    id_next       = job_id;
                    interval_next = job_interval;
                    ctx_next      = job_context;
                    tsec_next     = time_sec;
                    tusec_next    = time_usec;
                    idx_next      = '0;
                    wr_idx_next   = '0;
                    nfire_next    = '0;
                    pass_next     = 1'b0;
                    present_next  = 1'b0;
                    if (func == FN_ADD && count_reg < CNT_W'(MAX_JOBS))
                    begin
                        state_next = S_ADD_WR;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_ADD_WR:
            begin
                if (out_free)
                begin
                    wr.we            = 1'b1;
                    wr.waddr         = 7'(count_reg);
                    wr.wdata.id       = id_reg;
                    wr.wdata.interval = interval_reg;
                    wr.wdata.ctx      = ctx_reg;
                    wr.wdata.due_sec  = alu_sum_sec;
                    wr.wdata.due_usec = now_usec_reg;
                    count_next       = count_reg + 1'b1;
                    out_valid_next   = 1'b1;
                    out_kind_next    = K_DONE;
                    out_id_next      = id_reg;
                    out_ctx_next     = '0;
                    out_count_next   = 5'(count_reg + 1'b1);
                    out_present_next = 1'b1;
                    out_last_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_LOAD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_FINISH;
                    case (func_reg)
                        FN_TICK:
                        begin
                            if (nfire_reg == '0)
                            begin
                                now_sec_next  = tsec_reg;
                                now_usec_next = tusec_reg;
                                fin_kind_next = K_IDLE;
                            end
                            else
                            begin
                                pass_next  = 1'b1;
                                idx_next   = '0;
                                state_next = S_LOAD;
                            end
                        end
                        FN_ADD:
                        begin
                            fin_kind_next = K_FULL;
                        end
                        FN_REMOVE:
                        begin
                            count_next    = wr_idx_reg;
                            present_next  = 1'b0;
                            fin_kind_next = K_DONE;
                        end
                        default:
                        begin
                            fin_kind_next = K_DONE;
                        end
                    endcase
                end
            end
            S_EVAL:
            begin
                if (func_reg == FN_TICK && pass_reg)
                begin
                    if (!alu_due)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                    else if (out_free)
                    begin
                        wr.we            = 1'b1;
                        out_valid_next   = 1'b1;
                        out_kind_next    = K_FIRED;
                        out_id_next      = rdata.id;
                        out_ctx_next     = rdata.ctx;
                        out_count_next   = 5'(count_reg);
                        out_present_next = present_reg;
                        out_last_next    = (idx_reg[IDX_W-1:0] == last_idx_reg);
                        if (idx_reg[IDX_W-1:0] == last_idx_reg)
                        begin
                            now_sec_next  = tsec_reg;
                            now_usec_next = tusec_reg;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_LOAD;
                        end
                    end
                end
                else
                begin
                    if (match)
                    begin
                        present_next = 1'b1;
                    end
                    if (func_reg == FN_REMOVE && !match)
                    begin
                        wr.we       = 1'b1;
                        wr.waddr    = 7'(wr_idx_reg);
                        wr.wdata    = rdata;
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                    if (func_reg == FN_TICK && alu_due && nfire_reg < RES_W'(MAX_RESULTS))
                    begin
                        nfire_next    = nfire_reg + 1'b1;
                        last_idx_next = idx_reg[IDX_W-1:0];
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = fin_kind_reg;
                    out_id_next      = id_reg;
                    out_ctx_next     = '0;
                    out_count_next   = 5'(count_reg);
                    out_present_next = present_reg;
                    out_last_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            now_sec_reg   <= '0;
            now_usec_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            now_sec_reg   <= now_sec_next;
            now_usec_reg  <= now_usec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        id_reg          <= id_next;
        interval_reg    <= interval_next;
        ctx_reg         <= ctx_next;
        tsec_reg        <= tsec_next;
        tusec_reg       <= tusec_next;
        idx_reg         <= idx_next;
        wr_idx_reg      <= wr_idx_next;
        nfire_reg       <= nfire_next;
        last_idx_reg    <= last_idx_next;
        pass_reg        <= pass_next;
        present_reg     <= present_next;
        fin_kind_reg    <= fin_kind_next;
        out_kind_reg    <= out_kind_next;
        out_id_reg      <= out_id_next;
        out_ctx_reg     <= out_ctx_next;
        out_count_reg   <= out_count_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign fired_id      = out_id_reg;
    assign fired_context = out_ctx_reg;
    assign job_count     = out_count_reg;
    assign job_present   = out_present_reg;
    assign last          = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count exceeds table depth");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (state_reg == S_ADD_WR || state_reg == S_EVAL))
        else $error("table written outside a write state");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an operation is running");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && func_reg == FN_TICK) |-> nfire_reg <= RES_W'(MAX_RESULTS))
        else $error("fired count exceeds result limit");

endmodule
